[hdl/esg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential sine sweep generator package
// Widths, register codes, reset values and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package esg_pkg;

   localparam int PHASE_W         = 32;
   localparam int SAMPLE_W        = 16;
   localparam int AMP_W           = 15;
   localparam int CHCNT_W         = 4;
   localparam int CHAN_W          = 3;
   localparam int MAX_CHANNELS    = 8;
   localparam int SINE_TABLE_BITS = 10;
   localparam int TBL_N           = 1 << SINE_TABLE_BITS;
   localparam int TBL_W           = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_TUNING  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROWTH_FACTOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_TUNING   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic [PHASE_W-1:0] START_TUNING_RST  = 32'd894785;
   localparam logic [PHASE_W-1:0] GROWTH_FACTOR_RST = 32'd2147487943;
   localparam logic [PHASE_W-1:0] STOP_TUNING_RST   = 32'd2045222521;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RST     = 15'd16483;
   localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint SINE_FULL   = 64'sd32767;

   // 2^64 / (2n(2n+1)) rounded up, n = 1..6
   localparam logic [63:0] RECIP_6   = 64'(((65'd1 << 64) + 65'd5) / 65'd6);
   localparam logic [63:0] RECIP_20  = 64'(((65'd1 << 64) + 65'd19) / 65'd20);
   localparam logic [63:0] RECIP_42  = 64'(((65'd1 << 64) + 65'd41) / 65'd42);
   localparam logic [63:0] RECIP_72  = 64'(((65'd1 << 64) + 65'd71) / 65'd72);
   localparam logic [63:0] RECIP_110 = 64'(((65'd1 << 64) + 65'd109) / 65'd110);
   localparam logic [63:0] RECIP_156 = 64'(((65'd1 << 64) + 65'd155) / 65'd156);

   typedef logic [TBL_W-1:0] sine_table_type [TBL_N];

   typedef struct packed {
      logic                       en;
      logic [SINE_TABLE_BITS-1:0] addr;
   } sine_rd_type;

   // exact floor of a non-negative term (below 2^40) over 2n(2n+1)
   function automatic longint series_div(input longint t, input int n);
      logic [63:0]  recip;
      logic [127:0] prod;
      begin
         case (n)
            1:       recip = RECIP_6;
            2:       recip = RECIP_20;
            3:       recip = RECIP_42;
            4:       recip = RECIP_72;
            5:       recip = RECIP_110;
            default: recip = RECIP_156;
         endcase
         prod = {64'd0, t} * {64'd0, recip};
         return longint'(prod[127:64]);
      end
   endfunction

   // Taylor series in Q2.30 for x in [0, pi/2]
   function automatic longint sin_q30(input longint x);
      longint term;
      longint sum;
      begin
         term = x;
         sum  = x;
         for (int n = 1; n <= 6; n++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = series_div(term, n);
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         return sum;
      end
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      longint x;
      longint s;
      longint v;
      begin
         for (int k = 0; k < TBL_N; k++) begin
            x = (HALF_PI_Q30 * longint'(k)) >>> SINE_TABLE_BITS;
            s = sin_q30(x);
            v = (s * SINE_FULL + (64'sd1 <<< 29)) >>> 30;
            if (v > SINE_FULL) begin
               v = SINE_FULL;
            end
            if (v < 0) begin
               v = 0;
            end
            tbl[k] = v[TBL_W-1:0];
         end
         return tbl;
      end
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

[hdl/exponential_sine_sweep_generator_top.sv]
`timescale 1ns / 1ps
// Path: an accepted item's sine read is registered with the lookup stage, and the
// result register takes it once free; it emits one channel copy per cycle while
// rsp_ready is high, N copies, N the channel count clamped to 1..8; a finished tick emits one.
// Reset: registers that have a reset return to their reset values, then the sine RAM
// is loaded, during which no item is accepted (configuration writes are).
// ----------------------------------------------------------------------------
// Exponential sine sweep generator
// DDS chirp: phase accumulator, exponential tuning word growth, sine lookup,
// amplitude scaling and per-channel replication of each sample.
// ----------------------------------------------------------------------------
module exponential_sine_sweep_generator_top
   import esg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_restart,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic [CHAN_W-1:0]          rsp_channel,
   output logic                       rsp_last_of_frame,
   output logic                       rsp_finished,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // configuration
   logic [PHASE_W-1:0] start_ff, growth_ff, stop_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic [CHCNT_W-1:0] chcnt_ff;

   // sweep state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] tuning_ff, tuning_in;
   logic               done_ff, done_in;

   // lookup stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_done_ff, s1_neg_ff, s1_peak_ff;

   // result stage
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [CHAN_W-1:0]          out_chan_ff, out_chan_in;
   logic [CHAN_W-1:0]          out_last_ff, out_last_in;
   logic                       out_fin_ff, out_fin_in;

   logic                       accept, table_busy, out_free, out_last, s1_adv;
   logic [PHASE_W-1:0]         phase_cur, tuning_cur, tuning_grow;
   logic                       done_cur;
   logic [2*PHASE_W-1:0]       grow_prod, grow_round;
   logic [PHASE_W:0]           grow_q;
   logic [SINE_TABLE_BITS-1:0] tbl_k;
   sine_rd_type                rd_req;
   logic [TBL_W-1:0]           rd_data;
   logic [AMP_W-1:0]           mag_sel;
   logic [2*AMP_W-1:0]         mag_prod;
   logic [SAMPLE_W-1:0]        mag;
   logic [CHAN_W-1:0]          last_idx;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_TUNING_RST;
         growth_ff <= GROWTH_FACTOR_RST;
         stop_ff   <= STOP_TUNING_RST;
         amp_ff    <= AMPLITUDE_RST;
         chcnt_ff  <= CHANNEL_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_TUNING:  start_ff  <= csr_wdata;
            CSR_GROWTH_FACTOR: growth_ff <= csr_wdata;
            CSR_STOP_TUNING:   stop_ff   <= csr_wdata;
            CSR_AMPLITUDE:     amp_ff    <= csr_wdata[AMP_W-1:0];
            CSR_CHANNEL_COUNT: chcnt_ff  <= csr_wdata[CHCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_last  = out_chan_ff == out_last_ff;
   assign out_free  = !out_valid_ff || (rsp_ready && out_last);
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !table_busy && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   // sweep update
   assign phase_cur  = req_restart ? '0 : phase_ff;
   assign tuning_cur = req_restart ? start_ff : tuning_ff;
   assign done_cur   = req_restart ? 1'b0 : done_ff;

   assign grow_prod   = {{PHASE_W{1'b0}}, tuning_cur} * {{PHASE_W{1'b0}}, growth_ff};
   assign grow_round  = grow_prod + (64'd1 << 30);
   assign grow_q      = grow_round[2*PHASE_W-1:PHASE_W-1];
   assign tuning_grow = grow_q[PHASE_W] ? {PHASE_W{1'b1}} : grow_q[PHASE_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      tuning_in = tuning_ff;
      done_in   = done_ff;
      if (accept) begin
         phase_in  = phase_cur;
         tuning_in = tuning_cur;
         done_in   = done_cur;
         if (!done_cur) begin
            phase_in = phase_cur + tuning_cur;
            if (tuning_cur < stop_ff) begin
               tuning_in = tuning_grow;
            end else begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         tuning_ff <= START_TUNING_RST;
         done_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tuning_ff <= tuning_in;
         done_ff   <= done_in;
      end
   end

   // quarter-wave addressing
   assign tbl_k       = phase_cur[PHASE_W-3 -: SINE_TABLE_BITS];
   assign rd_req.en   = accept;
   assign rd_req.addr = phase_cur[PHASE_W-2] ? ({SINE_TABLE_BITS{1'b0}} - tbl_k) : tbl_k;

   esg_sine_table u_sine_table (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .rd_data (rd_data),
      .busy    (table_busy)
   );

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_done_ff <= done_cur;
         s1_neg_ff  <= phase_cur[PHASE_W-1];
         s1_peak_ff <= phase_cur[PHASE_W-2] && (tbl_k == '0);
      end
   end

   // amplitude scaling, truncation toward zero
   assign mag_sel  = s1_peak_ff ? {AMP_W{1'b1}} : rd_data[AMP_W-1:0];
   assign mag_prod = {{AMP_W{1'b0}}, amp_ff} * {{AMP_W{1'b0}}, mag_sel};
   assign mag      = {1'b0, mag_prod[2*AMP_W-1:AMP_W]};

   always_comb begin
      if (chcnt_ff == '0) begin
         last_idx = '0;
      end else if (chcnt_ff > CHCNT_W'(MAX_CHANNELS)) begin
         last_idx = CHAN_W'(MAX_CHANNELS - 1);
      end else begin
         last_idx = CHAN_W'(chcnt_ff - 1'b1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_chan_in   = out_chan_ff;
      out_last_in   = out_last_ff;
      out_fin_in    = out_fin_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         out_chan_in  = '0;
         out_fin_in   = s1_done_ff;
         if (s1_done_ff) begin
            out_sample_in = '0;
            out_last_in   = '0;
         end else begin
            out_sample_in = s1_neg_ff ? -$signed(mag) : $signed(mag);
            out_last_in   = last_idx;
         end
      end else if (rsp_ready) begin
         out_chan_in = out_chan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_chan_ff  <= '0;
         out_last_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         out_chan_ff  <= out_chan_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_fin_ff    <= out_fin_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample        = out_sample_ff;
   assign rsp_channel       = out_chan_ff;
   assign rsp_last_of_frame = out_last;
   assign rsp_finished      = out_fin_ff;

endmodule

[hdl/esg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/esg_sine_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine table store
// Loads the quarter-wave table into RAM after reset, then serves lookups.
// ----------------------------------------------------------------------------
module esg_sine_table
   import esg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sine_rd_type       rd_req,
   output logic [TBL_W-1:0]  rd_data,
   output logic              busy
);

   logic                       fill_run_ff, fill_run_in;
   logic [SINE_TABLE_BITS-1:0] fill_cnt_ff, fill_cnt_in;
   logic                       wr_en_ff, wr_en_in;
   logic [SINE_TABLE_BITS-1:0] wr_addr_ff;
   logic [TBL_W-1:0]           wr_data_ff;

   always_comb begin
      fill_run_in = fill_run_ff;
      fill_cnt_in = fill_cnt_ff;
      wr_en_in    = fill_run_ff;
      if (fill_run_ff) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
         if (fill_cnt_ff == {SINE_TABLE_BITS{1'b1}}) begin
            fill_run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_run_ff <= 1'b1;
         fill_cnt_ff <= '0;
         wr_en_ff    <= 1'b0;
      end else begin
         fill_run_ff <= fill_run_in;
         fill_cnt_ff <= fill_cnt_in;
         wr_en_ff    <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= fill_cnt_ff;
      wr_data_ff <= SINE_TABLE[fill_cnt_ff];
   end

   esg_ram #(
      .WIDTH (TBL_W),
      .DEPTH (TBL_N)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_data)
   );

   assign busy = fill_run_ff | wr_en_ff;

endmodule
